[rtl/srkf_pkg.sv]
`default_nettype none

package srkf_pkg;

  // Default sizes of the top level.
  localparam int unsigned PENDING_DEPTH_DEF = 16;
  localparam int unsigned SEQ_WIDTH_DEF     = 32;

  // Fixed field widths.
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned KEV_W    = 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned ACTION_W = 2;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 5'd16;

  // Key event codes.
  localparam logic [KEV_W-1:0] KEV_DOWN = 2'd1;
  localparam logic [KEV_W-1:0] KEV_UP   = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DISPATCH = 2'd0,
    ACT_DUP      = 2'd1,
    ACT_STALE    = 2'd2,
    ACT_OVERFLOW = 2'd3
  } srkf_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_INSERT,
    ST_INS_HEAD,
    ST_FINAL
  } srkf_state_t;

  // Everything of an event but its sequence number.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              main_kb;
    logic [KEV_W-1:0]  kev;
    logic [KEY_W-1:0]  code;
  } srkf_info_t;

  localparam int unsigned INFO_W = $bits(srkf_info_t);

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } srkf_keymem_t;

  typedef struct packed {
    srkf_keymem_t mem;
    srkf_action_t act;
  } srkf_filt_t;

  // Strobes from the control logic to the pending store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic push;
    logic pop;
  } srkf_store_op_t;

  // Key-up repeat filter applied at each in-order release.
  function automatic srkf_filt_t key_filter(srkf_keymem_t m, srkf_info_t e);
    srkf_filt_t r;
    r.mem = m;
    r.act = ACT_DISPATCH;
    if (e.main_kb) begin
      if (e.kev == KEV_DOWN) begin
        r.mem.valid = 1'b0;
      end else if (e.kev == KEV_UP) begin
        if (m.valid && (m.key == e.code)) begin
          r.act = ACT_DUP;
        end else begin
          r.mem.valid = 1'b1;
          r.mem.key   = e.code;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/srkf_store.sv]
`default_nettype none

// Pending store: a ring in one synchronous memory, addressed by the position
// in sort order (0 holds the smallest number). Pops move the head.
module srkf_store #(
  parameter int unsigned DEPTH   = srkf_pkg::PENDING_DEPTH_DEF,
  parameter int unsigned ENTRY_W = srkf_pkg::SEQ_WIDTH_DEF + srkf_pkg::INFO_W,
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire srkf_pkg::srkf_store_op_t op,
  input  wire  [IDX_W-1:0]           rd_idx,
  input  wire  [IDX_W-1:0]           wr_idx,
  input  wire  [ENTRY_W-1:0]         wr_data,
  output logic [ENTRY_W-1:0]         rd_data,
  output logic [CNT_W-1:0]           count
);

  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   rd_addr, wr_addr;

  function automatic logic [IDX_W-1:0] to_phys(logic [IDX_W-1:0] head,
                                                logic [IDX_W-1:0] idx);
    logic [IDX_W:0] s;
    s = {1'b0, head} + {1'b0, idx};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  assign rd_addr = to_phys(head_r, rd_idx);
  assign wr_addr = to_phys(head_r, wr_idx);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (op.pop) begin
      head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (op.push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (op.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;

endmodule

`default_nettype wire

[rtl/sequence_reorder_with_key_filter.sv]
`default_nettype none

// Reorder buffer for numbered input events with a key-up repeat filter.
// Events leave in sequence order: an event that carries the number after the
// last one released goes out at once as a dispatch (or as a skipped duplicate
// key-up), followed by every held event that continues the run; a later event
// is held in a sorted pending store of up to min(slot_count, PENDING_DEPTH)
// entries, or dropped as overflow when that store is full; an event at or
// below the last released number goes out as stale. out_last marks the final
// result of each input transaction; a held event produces no result at all.
// With no stall on the result side, the block accepts a transaction and then
// releases its results one per cycle. An event held into an empty store is
// written as it is accepted; otherwise the tail is read first and the store is
// shifted from its tail toward the insertion point one entry per cycle, and
// the event is written last. This shifting is set by the single read and
// single write port of the pending store memory. The store needs no clearing
// pass after reset.
// in_stall is high while a transaction is still being worked on; a finished
// result sits in the output register so a new transaction can be accepted
// while it waits. The slot_count register is written through the cfg_
// channel, which is always ready, and must only be written while idle.
module sequence_reorder_with_key_filter #(
  parameter int unsigned PENDING_DEPTH = srkf_pkg::PENDING_DEPTH_DEF,
  parameter int unsigned SEQ_WIDTH     = srkf_pkg::SEQ_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // Configuration write channel.
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [srkf_pkg::CFG_W-1:0]      cfg_slot_count,
  // Input event channel.
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [SEQ_WIDTH-1:0]            in_seq_id,
  input  wire  [srkf_pkg::SLOT_W-1:0]     in_slot,
  input  wire                             in_is_main_keyboard,
  input  wire  [srkf_pkg::KEV_W-1:0]      in_key_event,
  input  wire  [srkf_pkg::KEY_W-1:0]      in_key_code,
  // Result channel.
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [srkf_pkg::SLOT_W-1:0]     out_slot,
  output logic [SEQ_WIDTH-1:0]            out_seq,
  output logic [srkf_pkg::ACTION_W-1:0]   out_action,
  output logic                            out_last
);

  localparam int unsigned ENTRY_W = SEQ_WIDTH + srkf_pkg::INFO_W;
  localparam int unsigned IDX_W   = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned CMP_W   = (CNT_W > srkf_pkg::CFG_W) ? CNT_W : srkf_pkg::CFG_W;

  // Control state.
  srkf_pkg::srkf_state_t state_r, state_nxt;
  logic [srkf_pkg::CFG_W-1:0] slot_count_r, slot_count_nxt;
  logic [SEQ_WIDTH-1:0]       last_seq_r, last_seq_nxt;
  srkf_pkg::srkf_keymem_t     keymem_r, keymem_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Event being worked on, the staged result and the insertion cursor.
  logic [SEQ_WIDTH-1:0]       ev_seq_r, ev_seq_nxt;
  srkf_pkg::srkf_info_t       ev_info_r, ev_info_nxt;
  logic [SEQ_WIDTH-1:0]       res_seq_r, res_seq_nxt;
  logic [srkf_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  srkf_pkg::srkf_action_t     res_act_r, res_act_nxt;
  logic [IDX_W-1:0]           k_r, k_nxt;

  // Output register.
  logic [SEQ_WIDTH-1:0]        out_seq_r;
  logic [srkf_pkg::SLOT_W-1:0] out_slot_r;
  srkf_pkg::srkf_action_t      out_act_r;
  logic                        out_last_r;
  logic                        out_load;
  logic                        out_last_nxt;

  // Pending store interface.
  srkf_pkg::srkf_store_op_t op;
  logic [IDX_W-1:0]         rd_idx, wr_idx;
  logic [ENTRY_W-1:0]       wr_data, rd_data;
  logic [CNT_W-1:0]         count;

  srkf_pkg::srkf_info_t in_info, rd_info, filt_info;
  srkf_pkg::srkf_filt_t filt;
  logic [SEQ_WIDTH-1:0] rd_seq, next_seq;
  logic [ENTRY_W-1:0]   in_entry, ev_entry;
  logic [IDX_W-1:0]     tail_idx;
  logic                 in_take, in_ordered, in_later, st_full;
  logic                 drain_match, ins_shift, out_free, more_held;

  srkf_store #(
    .DEPTH   (PENDING_DEPTH),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .rd_idx  (rd_idx),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .count   (count)
  );

  assign in_info.slot    = in_slot;
  assign in_info.main_kb = in_is_main_keyboard;
  assign in_info.kev     = in_key_event;
  assign in_info.code    = in_key_code;

  assign in_entry = {in_seq_id, in_info};
  assign ev_entry = {ev_seq_r, ev_info_r};
  assign rd_seq   = rd_data[ENTRY_W-1 -: SEQ_WIDTH];
  assign rd_info  = rd_data[srkf_pkg::INFO_W-1:0];
  assign next_seq = last_seq_r + 1'b1;
  assign tail_idx = IDX_W'(count - 1'b1);

  // The store is full at min(slot_count, PENDING_DEPTH) entries.
  assign st_full = (CMP_W'(count) >= CMP_W'(slot_count_r)) ||
                   (count >= CNT_W'(PENDING_DEPTH));

  assign in_stall    = (state_r != srkf_pkg::ST_IDLE);
  assign in_take     = in_valid && !in_stall;
  assign in_ordered  = (in_seq_id == next_seq);
  assign in_later    = (in_seq_id > last_seq_r);
  // While draining, rd_data holds the head of the store.
  assign drain_match = (rd_seq == next_seq);
  assign more_held   = (count > CNT_W'(1));
  // While inserting, rd_data holds the entry at the cursor.
  assign ins_shift   = (rd_seq > ev_seq_r);
  assign out_free    = !out_valid_r || !out_stall;

  // Only one release can happen per cycle, so one filter serves both sources.
  assign filt_info = (state_r == srkf_pkg::ST_DRAIN) ? rd_info : in_info;
  assign filt      = srkf_pkg::key_filter(keymem_r, filt_info);

  assign cfg_ready      = 1'b1;
  assign slot_count_nxt = cfg_valid ? cfg_slot_count : slot_count_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srkf_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_ordered) begin
            state_nxt = (count != '0) ? srkf_pkg::ST_DRAIN : srkf_pkg::ST_FINAL;
          end else if (in_later) begin
            if (st_full) begin
              state_nxt = srkf_pkg::ST_FINAL;
            end else if (count != '0) begin
              state_nxt = srkf_pkg::ST_INSERT;
            end
          end else begin
            state_nxt = srkf_pkg::ST_FINAL;
          end
        end
      end
      srkf_pkg::ST_DRAIN: begin
        if (out_free) begin
          if (!drain_match) begin
            state_nxt = srkf_pkg::ST_IDLE;
          end else if (!more_held) begin
            state_nxt = srkf_pkg::ST_FINAL;
          end
        end
      end
      srkf_pkg::ST_INSERT: begin
        if (!ins_shift) begin
          state_nxt = srkf_pkg::ST_IDLE;
        end else if (k_r == '0) begin
          state_nxt = srkf_pkg::ST_INS_HEAD;
        end
      end
      srkf_pkg::ST_INS_HEAD: begin
        state_nxt = srkf_pkg::ST_IDLE;
      end
      srkf_pkg::ST_FINAL: begin
        if (out_free) begin
          state_nxt = srkf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = srkf_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and store control.
  always_comb begin
    op           = '0;
    rd_idx       = '0;
    wr_idx       = '0;
    wr_data      = ev_entry;
    out_load     = 1'b0;
    out_last_nxt = 1'b1;
    last_seq_nxt = last_seq_r;
    keymem_nxt   = keymem_r;
    ev_seq_nxt   = ev_seq_r;
    ev_info_nxt  = ev_info_r;
    res_seq_nxt  = res_seq_r;
    res_slot_nxt = res_slot_r;
    res_act_nxt  = res_act_r;
    k_nxt        = k_r;
    case (state_r)
      srkf_pkg::ST_IDLE: begin
        if (in_take) begin
          ev_seq_nxt   = in_seq_id;
          ev_info_nxt  = in_info;
          res_seq_nxt  = in_seq_id;
          res_slot_nxt = in_slot;
          if (in_ordered) begin
            // Released at once; prefetch the head to see whether it follows.
            res_act_nxt  = filt.act;
            keymem_nxt   = filt.mem;
            last_seq_nxt = next_seq;
            op.rd_en     = (count != '0);
          end else if (in_later) begin
            if (st_full) begin
              res_act_nxt = srkf_pkg::ACT_OVERFLOW;
            end else if (count == '0) begin
              op.wr_en = 1'b1;
              op.push  = 1'b1;
              wr_data  = in_entry;
            end else begin
              // Walk back from the tail, shifting larger entries up by one.
              op.rd_en = 1'b1;
              rd_idx   = tail_idx;
              k_nxt    = tail_idx;
            end
          end else begin
            res_act_nxt = srkf_pkg::ACT_STALE;
          end
        end
      end
      srkf_pkg::ST_DRAIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = !drain_match;
          if (drain_match) begin
            res_seq_nxt  = rd_seq;
            res_slot_nxt = rd_info.slot;
            res_act_nxt  = filt.act;
            keymem_nxt   = filt.mem;
            last_seq_nxt = next_seq;
            op.pop       = 1'b1;
            // Read the entry that becomes the head after this pop.
            op.rd_en     = more_held;
            rd_idx       = IDX_W'(1);
          end
        end
      end
      srkf_pkg::ST_INSERT: begin
        op.wr_en = 1'b1;
        wr_idx   = k_r + 1'b1;
        if (ins_shift) begin
          wr_data = rd_data;
          if (k_r != '0) begin
            op.rd_en = 1'b1;
            rd_idx   = k_r - 1'b1;
            k_nxt    = k_r - 1'b1;
          end
        end else begin
          op.push = 1'b1;
        end
      end
      srkf_pkg::ST_INS_HEAD: begin
        op.wr_en = 1'b1;
        op.push  = 1'b1;
      end
      srkf_pkg::ST_FINAL: begin
        out_load = out_free;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= srkf_pkg::ST_IDLE;
      slot_count_r <= srkf_pkg::SLOT_COUNT_RST;
      last_seq_r   <= '0;
      keymem_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      last_seq_r   <= last_seq_nxt;
      keymem_r     <= keymem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_seq_r   <= ev_seq_nxt;
    ev_info_r  <= ev_info_nxt;
    res_seq_r  <= res_seq_nxt;
    res_slot_r <= res_slot_nxt;
    res_act_r  <= res_act_nxt;
    k_r        <= k_nxt;
    if (out_load) begin
      out_seq_r  <= res_seq_r;
      out_slot_r <= res_slot_r;
      out_act_r  <= res_act_r;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_seq    = out_seq_r;
  assign out_slot   = out_slot_r;
  assign out_action = out_act_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

[rtl/srkf_checker.sv]
`default_nettype none

module srkf_checker #(
  parameter int unsigned SEQ_WIDTH = srkf_pkg::SEQ_WIDTH_DEF
) (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_valid,
  input wire                           out_stall,
  input wire [srkf_pkg::SLOT_W-1:0]    out_slot,
  input wire [SEQ_WIDTH-1:0]           out_seq,
  input wire [srkf_pkg::ACTION_W-1:0]  out_action,
  input wire                           out_last
);

  logic                 chain_r;
  logic [SEQ_WIDTH-1:0] chain_seq_r;

  // Tracks whether the last result taken was an in-order release with more to come.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      chain_r <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      chain_seq_r <= out_seq;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seq) && $stable(out_slot) &&
                                $stable(out_action) && $stable(out_last))
    else $error("stalled result changed");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == srkf_pkg::ACT_STALE ||
                  out_action == srkf_pkg::ACT_OVERFLOW) |-> out_last)
    else $error("stale or overflow result not marked last");

  a_run_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && chain_r |->
      (out_seq == chain_seq_r + 1'b1) &&
      (out_action == srkf_pkg::ACT_DISPATCH || out_action == srkf_pkg::ACT_DUP))
    else $error("released run broke sequence order");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sequence_reorder_with_key_filter srkf_checker #(
  .SEQ_WIDTH (SEQ_WIDTH)
) u_srkf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_slot   (out_slot),
  .out_seq    (out_seq),
  .out_action (out_action),
  .out_last   (out_last)
);

`default_nettype wire
